// ----- design/jcs_pkg.sv -----
package jcs_pkg;

  localparam int BUFFER_BYTES = 512;
  localparam int RESET_TICKS  = 5;
  localparam int BUF_AW       = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [2:0] CMD_TAP_RESET = 3'd0;
  localparam logic [2:0] CMD_TMS       = 3'd1;
  localparam logic [2:0] CMD_SCAN      = 3'd2;
  localparam logic [2:0] CMD_SCAN_EXIT = 3'd3;
  localparam logic [2:0] CMD_STOP      = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [8:0]  byte_index;
    logic [7:0]  byte_value;
    logic [2:0]  command;
    logic [12:0] bit_count;
    logic        tdo_sample;
  } jcs_in_t;

  typedef struct packed {
    logic       tck_pulse;
    logic       tms_level;
    logic       tdi_level;
    logic       busy_res;
    logic       done_res;
    logic       close_link;
    logic       bad_command;
    logic [7:0] read_value;
  } jcs_out_t;

  // request classified by the front, waiting on buffer read data
  typedef struct packed {
    logic       tck;
    logic       tms_we;
    logic       tms_from_tdi;
    logic       tms_v;
    logic       tdi_we;
    logic       bit_ok;
    logic [2:0] bit_sel;
    logic       busy;
    logic       done;
    logic       closing;
    logic       bad;
    logic       rd_ok;
  } jcs_desc_t;

  // fully resolved request handed to the back end
  typedef struct packed {
    logic       tck;
    logic       tms_we;
    logic       tms_v;
    logic       tdi_we;
    logic       tdi_v;
    logic       busy;
    logic       done;
    logic       closing;
    logic       bad;
    logic [7:0] rd;
  } jcs_entry_t;

endpackage

// ----- design/jcs_front.sv -----
module jcs_front import jcs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  jcs_in_t         in_data,
  input  logic [QCW-1:0]  q_count,
  output logic            ent_valid,
  output jcs_entry_t      ent
);

  logic [7:0] out_mem [BUFFER_BYTES];
  logic [7:0] cap_mem [BUFFER_BYTES];
  logic [7:0] om_dout_r;
  logic [7:0] cm_dout_r;

  logic        running_r, running_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [12:0] pos_r, pos_nxt;
  logic [12:0] total_r, total_nxt;
  logic [7:0]  acc_r, acc_nxt;

  logic        s1_valid_r;
  jcs_desc_t   s1_r;
  jcs_desc_t   desc;

  logic              acc_in;
  logic              idx_ok;
  logic              pos_ok;
  logic [12:0]       pos_inc;
  logic [BUF_AW-1:0] idx_addr;
  logic [BUF_AW-1:0] pos_addr;
  logic              om_we, om_re, cm_we, cm_re;
  logic              tdi_bit;

  assign in_ready = (int'(q_count) + int'(s1_valid_r)) < QDEPTH;
  assign acc_in   = in_valid && in_ready;

  assign idx_ok   = 32'(in_data.byte_index) < BUFFER_BYTES;
  assign pos_ok   = 32'(pos_r[12:3]) < BUFFER_BYTES;
  assign idx_addr = BUF_AW'(in_data.byte_index);
  assign pos_addr = BUF_AW'(pos_r[12:3]);
  assign pos_inc  = pos_r + 13'd1;

  always_comb begin
    running_nxt = running_r;
    cmd_nxt     = cmd_r;
    pos_nxt     = pos_r;
    total_nxt   = total_r;
    acc_nxt     = acc_r;
    om_we       = 1'b0;
    om_re       = 1'b0;
    cm_we       = 1'b0;
    cm_re       = 1'b0;
    desc        = '0;
    desc.closing = running_r && (cmd_r == CMD_STOP);
    desc.bit_sel = pos_r[2:0];
    unique case (in_data.opcode)
      OP_WRITE: begin
        om_we = !running_r && idx_ok;
      end
      OP_READ: begin
        cm_re      = !running_r && idx_ok;
        desc.rd_ok = cm_re;
      end
      OP_START: begin
        if (!running_r) begin
          if (in_data.command > CMD_STOP) begin
            desc.bad  = 1'b1;
            desc.done = 1'b1;
          end else begin
            cmd_nxt     = in_data.command;
            total_nxt   = in_data.bit_count;
            pos_nxt     = '0;
            running_nxt = 1'b1;
            if (in_data.command == CMD_STOP) desc.closing = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (running_r) begin
          desc.tck = 1'b1;
          pos_nxt  = pos_inc;
          if (cmd_r == CMD_TAP_RESET || cmd_r == CMD_STOP) begin
            desc.tms_we = 1'b1;
            desc.tms_v  = 1'b1;
            if (32'(pos_inc) >= RESET_TICKS) running_nxt = 1'b0;
          end else begin
            desc.tdi_we = 1'b1;
            desc.tms_we = 1'b1;
            desc.bit_ok = pos_ok;
            om_re       = pos_ok;
            if (cmd_r == CMD_TMS) begin
              desc.tms_from_tdi = 1'b1;
            end else begin
              if (cmd_r == CMD_SCAN_EXIT) begin
                desc.tms_v = (total_r != '0) && (pos_r >= total_r - 13'd1);
              end
              if (pos_ok) begin
                acc_nxt = ((pos_r[2:0] == 3'd0) ? 8'h00 : acc_r)
                          | (8'(in_data.tdo_sample) << pos_r[2:0]);
                cm_we   = 1'b1;
              end
            end
            if (pos_inc >= total_r) running_nxt = 1'b0;
          end
          if (!running_nxt) desc.done = 1'b1;
        end
      end
    endcase
    desc.busy = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= 1'b0;
      cmd_r      <= CMD_TAP_RESET;
      pos_r      <= '0;
      total_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc_in;
      if (acc_in) begin
        running_r <= running_nxt;
        cmd_r     <= cmd_nxt;
        pos_r     <= pos_nxt;
        total_r   <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_r  <= desc;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && om_we) out_mem[idx_addr] <= in_data.byte_value;
    if (acc_in && om_re) om_dout_r <= out_mem[pos_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_in && cm_we) cap_mem[pos_addr] <= acc_nxt;
    if (acc_in && cm_re) cm_dout_r <= cap_mem[idx_addr];
  end

  assign tdi_bit    = s1_r.bit_ok ? om_dout_r[s1_r.bit_sel] : 1'b0;
  assign ent_valid  = s1_valid_r;
  assign ent.tck    = s1_r.tck;
  assign ent.tms_we = s1_r.tms_we;
  assign ent.tms_v  = s1_r.tms_from_tdi ? tdi_bit : s1_r.tms_v;
  assign ent.tdi_we = s1_r.tdi_we;
  assign ent.tdi_v  = tdi_bit;
  assign ent.busy   = s1_r.busy;
  assign ent.done   = s1_r.done;
  assign ent.closing = s1_r.closing;
  assign ent.bad    = s1_r.bad;
  assign ent.rd     = s1_r.rd_ok ? cm_dout_r : 8'h00;

endmodule

// ----- design/jcs_queue.sv -----
module jcs_queue import jcs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jcs_entry_t      push_data,
  input  logic            pop,
  output jcs_entry_t      head,
  output logic            empty,
  output logic [QCW-1:0]  count
);

  jcs_entry_t     slots [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  assign head  = slots[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  always_comb begin
    wr_ptr_nxt = push ? QAW'(32'(wr_ptr_r) + 1 == QDEPTH ? 0 : 32'(wr_ptr_r) + 1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QAW'(32'(rd_ptr_r) + 1 == QDEPTH ? 0 : 32'(rd_ptr_r) + 1) : rd_ptr_r;
    count_nxt  = QCW'(32'(count_r) + 32'(push) - 32'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= push_data;
  end

endmodule

// ----- design/jcs_back.sv -----
module jcs_back import jcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  jcs_entry_t  head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output jcs_out_t    out_data
);

  logic     held_tms_r, held_tms_nxt;
  logic     held_tdi_r, held_tdi_nxt;
  logic     out_valid_r;
  jcs_out_t out_r, out_nxt;

  assign pop = !empty && (!out_valid_r || out_ready);

  always_comb begin
    held_tms_nxt = head.tms_we ? head.tms_v : held_tms_r;
    held_tdi_nxt = head.tdi_we ? head.tdi_v : held_tdi_r;
    out_nxt.tck_pulse   = head.tck;
    out_nxt.tms_level   = held_tms_nxt;
    out_nxt.tdi_level   = held_tdi_nxt;
    out_nxt.busy_res    = head.busy;
    out_nxt.done_res    = head.done;
    out_nxt.close_link  = head.closing;
    out_nxt.bad_command = head.bad;
    out_nxt.read_value  = head.rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_tms_r  <= 1'b0;
      held_tdi_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        held_tms_r  <= held_tms_nxt;
        held_tdi_r  <= held_tdi_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/jtag_command_shifter_top.sv -----
// channel  | valid     | ready     | payload
// request  | in_valid  | in_ready  | in_data  (jcs_in_t)
// result   | out_valid | out_ready | out_data (jcs_out_t)
//
// One request per clock while in_ready is high, one result per request, results in request order.
// A request is registered in the front end, passes through the queue and is registered again in the back end.
// Sync active-low reset clears control state only; both byte buffers read
// undefined until written, and no clearing pass runs.
// A four-entry queue between front and back end lets input keep flowing
// while out_ready is low, until the queue fills.
module jtag_command_shifter_top import jcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  jcs_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output jcs_out_t  out_data
);

  logic           ent_valid;
  jcs_entry_t     ent;
  jcs_entry_t     head;
  logic           q_empty;
  logic           q_pop;
  logic [QCW-1:0] q_count;

  jcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_count   (q_count),
    .ent_valid (ent_valid),
    .ent       (ent)
  );

  jcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ent_valid),
    .push_data (ent),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .count     (q_count)
  );

  jcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- design/jcs_checker.sv -----
module jcs_checker import jcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  jcs_in_t   in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  jcs_out_t  out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_bad_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_command |->
      out_data.done_res && !out_data.busy_res && !out_data.tck_pulse)
    else $error("bad command result inconsistent");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done while still busy");

  a_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.read_value != 8'h00) |->
      !out_data.busy_res && !out_data.tck_pulse)
    else $error("read data returned while busy");

endmodule

bind jtag_command_shifter_top jcs_checker u_chk (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import jcs_pkg::*;

  localparam int PLAN = 0;
  localparam int LIVE = 1;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  jcs_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  jcs_out_t out_data;

  jtag_command_shifter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // engine state: PLAN tracks generation, LIVE tracks accepted requests
  bit [7:0]  obuf    [2][BUFFER_BYTES];
  bit        obuf_wr [2][BUFFER_BYTES];
  bit [7:0]  cbuf    [2][BUFFER_BYTES];
  bit        cbuf_wr [2][BUFFER_BYTES];
  bit [12:0] pos_r   [2];
  bit [12:0] total_r [2];
  bit [2:0]  cmd_r   [2];
  bit        run_r   [2];
  bit        tms_r   [2];
  bit        tdi_r   [2];

  jcs_in_t  pend_q[$];
  bit       hold_q[$];
  jcs_out_t exp_q[$];
  jcs_out_t want;
  int       errors;
  int       acc;
  int       total;
  bit       in_took;

  function automatic jcs_out_t engine_step(int s, jcs_in_t rq);
    jcs_out_t r;
    int       pos;
    int       b;
    bit       fin;
    r   = '0;
    fin = 1'b0;
    if (run_r[s] && cmd_r[s] == CMD_STOP) r.close_link = 1'b1;
    case (rq.opcode)
      OP_WRITE: begin
        if (!run_r[s]) begin
          obuf[s][rq.byte_index]    = rq.byte_value;
          obuf_wr[s][rq.byte_index] = 1'b1;
        end
      end
      OP_READ: begin
        if (!run_r[s]) r.read_value = cbuf[s][rq.byte_index];
      end
      OP_START: begin
        if (!run_r[s]) begin
          if (rq.command > CMD_STOP) begin
            r.bad_command = 1'b1;
            r.done_res    = 1'b1;
          end else begin
            cmd_r[s]   = rq.command;
            total_r[s] = rq.bit_count;
            pos_r[s]   = '0;
            run_r[s]   = 1'b1;
            if (rq.command == CMD_STOP) r.close_link = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (run_r[s]) begin
          r.tck_pulse = 1'b1;
          if (cmd_r[s] == CMD_TAP_RESET || cmd_r[s] == CMD_STOP) begin
            tms_r[s] = 1'b1;
            pos_r[s] = pos_r[s] + 13'd1;
            fin      = (int'(pos_r[s]) >= RESET_TICKS);
          end else begin
            pos      = int'(pos_r[s]);
            b        = pos >> 3;
            tdi_r[s] = (b < BUFFER_BYTES) ? obuf[s][b][pos % 8] : 1'b0;
            if (cmd_r[s] == CMD_TMS) begin
              tms_r[s] = tdi_r[s];
            end else begin
              tms_r[s] = (cmd_r[s] == CMD_SCAN_EXIT) && (total_r[s] != 0) &&
                         (pos >= int'(total_r[s]) - 1);
              if (b < BUFFER_BYTES) begin
                if (pos % 8 == 0) cbuf[s][b] = 8'd0;
                cbuf[s][b]    = cbuf[s][b] | (8'(rq.tdo_sample) << (pos % 8));
                cbuf_wr[s][b] = 1'b1;
              end
            end
            pos_r[s] = 13'(pos + 1);
            fin      = (pos_r[s] >= total_r[s]);
          end
          if (fin) begin
            run_r[s]   = 1'b0;
            r.done_res = 1'b1;
          end
        end
      end
    endcase
    r.tms_level = tms_r[PLAN == s ? PLAN : LIVE];
    r.tdi_level = tdi_r[s];
    r.busy_res  = run_r[s];
    return r;
  endfunction

  function automatic jcs_in_t rand_req(logic [1:0] op);
    jcs_in_t r;
    r.opcode     = op;
    r.byte_index = 9'($urandom_range(0, 511));
    r.byte_value = 8'($urandom_range(0, 255));
    r.command    = 3'($urandom_range(0, 7));
    r.bit_count  = 13'($urandom_range(0, 8191));
    r.tdo_sample = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic jcs_in_t wr_req(int idx, logic [7:0] val);
    jcs_in_t r;
    r            = rand_req(OP_WRITE);
    r.byte_index = 9'(idx);
    r.byte_value = val;
    return r;
  endfunction

  function automatic jcs_in_t rd_req(int idx);
    jcs_in_t r;
    r            = rand_req(OP_READ);
    r.byte_index = 9'(idx);
    return r;
  endfunction

  task automatic push_req(jcs_in_t rq, bit hold);
    jcs_out_t unused;
    pend_q.push_back(rq);
    hold_q.push_back(hold);
    unused = engine_step(PLAN, rq);
  endtask

  // fills any not yet written outgoing bytes a shift will use, then queues the start
  task automatic launch(logic [2:0] cmd, logic [12:0] cnt, bit hold);
    jcs_in_t rq;
    int      nb;
    if (cmd == CMD_TMS || cmd == CMD_SCAN || cmd == CMD_SCAN_EXIT) begin
      nb = ((cnt == 0 ? 1 : int'(cnt)) + 7) / 8;
      if (nb > BUFFER_BYTES) nb = BUFFER_BYTES;
      for (int i = 0; i < nb; i++)
        if (!obuf_wr[PLAN][i]) push_req(wr_req(i, 8'($urandom_range(0, 255))), 1'b0);
    end
    rq           = rand_req(OP_START);
    rq.command   = cmd;
    rq.bit_count = cnt;
    push_req(rq, hold);
  endtask

  task automatic drain(int noise_pct);
    while (run_r[PLAN]) begin
      if ($urandom_range(0, 99) < noise_pct)
        push_req(rand_req(2'($urandom_range(0, 3))), 1'b0);
      else
        push_req(rand_req(OP_TICK), 1'b0);
    end
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  function automatic int tx_idle_pct();
    case (acc * 3 / total)
      0:       return 23;
      1:       return 49;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (acc * 3 / total)
      0:       return 49;
      1:       return 23;
      default: return 0;
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct());
      if (!in_valid || in_took) begin
        in_took = 1'b0;
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct() &&
            !(hold_q[0] && exp_q.size() != 0)) begin
          in_valid <= 1'b1;
          in_data  <= pend_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // results are checked before this edge's request is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none actual %p", $time, out_data);
        end else begin
          want = exp_q.pop_front();
          check_field("tck_pulse", want.tck_pulse, out_data.tck_pulse);
          check_field("tms_level", want.tms_level, out_data.tms_level);
          check_field("tdi_level", want.tdi_level, out_data.tdi_level);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("close_link", want.close_link, out_data.close_link);
          check_field("bad_command", want.bad_command, out_data.bad_command);
          check_field("read_value", want.read_value, out_data.read_value);
        end
      end
      if (in_valid && in_ready) begin
        exp_q.push_back(engine_step(LIVE, in_data));
        void'(pend_q.pop_front());
        void'(hold_q.pop_front());
        acc++;
        in_took = 1'b1;
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int         r;
    int         idx;
    logic [2:0] cmd;
    logic [12:0] cnt;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    in_took   = 1'b0;
    errors    = 0;
    acc       = 0;

    // directed
    push_req(rand_req(OP_TICK), 1'b0);
    push_req(wr_req(0, 8'hFF), 1'b0);
    push_req(wr_req(1, 8'h00), 1'b0);
    push_req(wr_req(BUFFER_BYTES - 1, 8'h5A), 1'b0);
    launch(CMD_TAP_RESET, 13'h1FFF, 1'b1);
    drain(0);
    launch(CMD_TMS, 13'd0, 1'b0);
    drain(0);
    launch(CMD_SCAN, 13'd0, 1'b0);
    drain(0);
    push_req(rd_req(0), 1'b0);
    launch(CMD_SCAN_EXIT, 13'd3, 1'b0);
    push_req(wr_req(1, 8'hFF), 1'b0);
    push_req(rand_req(OP_START), 1'b0);
    push_req(rd_req(5), 1'b0);
    drain(0);
    launch(CMD_SCAN_EXIT, 13'd1, 1'b0);
    drain(0);
    launch(3'd7, 13'd0, 1'b0);
    launch(3'd5, 13'h1000, 1'b0);
    launch(CMD_STOP, 13'd0, 1'b0);
    drain(0);
    push_req(rd_req(0), 1'b0);

    // random
    while (pend_q.size() < 550) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        r = $urandom_range(0, 99);
        if (r < 25)      cmd = CMD_TMS;
        else if (r < 50) cmd = CMD_SCAN;
        else if (r < 75) cmd = CMD_SCAN_EXIT;
        else if (r < 83) cmd = CMD_TAP_RESET;
        else if (r < 91) cmd = CMD_STOP;
        else             cmd = 3'($urandom_range(5, 7));
        if (cmd == CMD_TMS || cmd == CMD_SCAN || cmd == CMD_SCAN_EXIT)
          cnt = ($urandom_range(0, 99) < 80) ? 13'($urandom_range(0, 24))
                                              : 13'($urandom_range(25, 300));
        else
          cnt = 13'($urandom_range(0, 8191));
        launch(cmd, cnt, $urandom_range(0, 99) < 5);
        drain(8);
      end else if (r < 70) begin
        push_req(rand_req(OP_WRITE), 1'b0);
      end else if (r < 88) begin
        idx = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 511) : $urandom_range(0, 40);
        if (cbuf_wr[PLAN][idx]) push_req(rd_req(idx), 1'b0);
        else                    push_req(wr_req(idx, 8'($urandom_range(0, 255))), 1'b0);
      end else begin
        push_req(rand_req(OP_TICK), 1'b0);
      end
    end
    total = pend_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (acc < total || exp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- jtag_command_shifter_top.f -----
design/jcs_pkg.sv
design/jcs_front.sv
design/jcs_queue.sv
design/jcs_back.sv
design/jtag_command_shifter_top.sv
design/jcs_checker.sv
tb/tb.sv
